/* hw/rtl/dti_pkg.sv */
package dti_pkg;

   // fixed field widths of the request and response beats
   localparam int KIND_W   = 2;
   localparam int ID_W     = 8;
   localparam int FEAT_W   = 7;
   localparam int LINK_W   = 9;
   localparam int CLASS_W  = 8;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 9;

   // feature index bits once the sign is known to be clear
   localparam int FEAT_IDX_W = FEAT_W - 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_SAMPLE = 2'd3
   } dti_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 3'd0,
      STATUS_DUPLICATE    = 3'd1,
      STATUS_MISSING      = 3'd2,
      STATUS_HAS_CHILDREN = 3'd3,
      STATUS_SHORT        = 3'd4,
      STATUS_WALK_MISSING = 3'd5,
      STATUS_DEPTH        = 3'd6
   } dti_status_type;

   // one update to the slot table per cycle at most
   typedef struct packed {
      logic set;
      logic drop;
      logic wipe;
   } dti_slot_op_type;

endpackage

/* hw/rtl/decision_tree_inference_top.sv */
// Channel   Direction  Handshake             Ports
// request   in         start && !busy        req_kind .. req_last
// response  out        rsp_strobe, 1 cycle   rsp_status, rsp_class_out, rsp_node_total
//
// Insert, clear and samples that start no walk finish with busy low; a remove of a present
// node reads the node, then checks it. A walk reads the node RAM, then the feature RAM, then
// compares per link taken; it ends at a leaf, a short vector, a bad link or WALK_LIMIT steps.
// The response beat shows in the cycle after the item ends; a non-last sample has none.
// Reset is synchronous; slot valid bits, node and sample counters and the FSM clear at once.
// The receiver cannot stall: every response beat is a one-cycle strobe.
module decision_tree_inference_top #(
   parameter int NODES      = 256,
   parameter int FEATURES   = 64,
   parameter int WALK_LIMIT = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [dti_pkg::KIND_W-1:0]            req_kind,
   input  logic [dti_pkg::ID_W-1:0]              req_node_id,
   input  logic signed [VALUE_BITS-1:0]          req_threshold,
   input  logic signed [dti_pkg::FEAT_W-1:0]     req_split_feature,
   input  logic signed [dti_pkg::LINK_W-1:0]     req_left_child,
   input  logic signed [dti_pkg::LINK_W-1:0]     req_right_child,
   input  logic [dti_pkg::CLASS_W-1:0]           req_class_id,
   input  logic signed [VALUE_BITS-1:0]          req_feature_value,
   input  logic                                  req_last,
   output logic                                  rsp_strobe,
   output logic [dti_pkg::STATUS_W-1:0]          rsp_status,
   output logic [dti_pkg::CLASS_W-1:0]           rsp_class_out,
   output logic [dti_pkg::TOTAL_W-1:0]           rsp_node_total
);

   import dti_pkg::*;

   localparam int NODE_AW = $clog2(NODES);
   localparam int FEAT_AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int FCNT_W  = $clog2(FEATURES + 1);
   localparam int STEP_W  = $clog2(WALK_LIMIT + 1);
   localparam int CNT_W   = $clog2(NODES + 1);

   // node word: {threshold, feature, left, right, class}
   localparam int RIGHT_LSB = CLASS_W;
   localparam int LEFT_LSB  = RIGHT_LSB + LINK_W;
   localparam int FEAT_LSB  = LEFT_LSB + LINK_W;
   localparam int THR_LSB   = FEAT_LSB + FEAT_W;
   localparam int NODE_W    = THR_LSB + VALUE_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_REMOVE,
      S_NODE,
      S_FEATURE
   } state_type;

   state_type state_ff, state_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   dti_status_type        rsp_status_ff, rsp_status_in;
   logic [CLASS_W-1:0]    rsp_class_ff, rsp_class_in;

   logic [FCNT_W-1:0]     loaded_ff, loaded_in;
   logic [FCNT_W-1:0]     walk_loaded_ff, walk_loaded_in;
   logic [FEAT_IDX_W-1:0] largest_ff, largest_in;
   logic [STEP_W-1:0]     steps_ff, steps_in;
   logic [NODE_AW-1:0]    rm_addr_ff, rm_addr_in;
   logic [VALUE_BITS-1:0] thr_ff, thr_in;
   logic [LINK_W-1:0]     left_ff, left_in;
   logic [LINK_W-1:0]     right_ff, right_in;

   // memory ports
   logic                  node_we;
   logic [NODE_AW-1:0]    node_raddr;
   logic [NODE_W-1:0]     node_wdata;
   logic [NODE_W-1:0]     node_rdata;
   logic                  feat_we;
   logic [FEAT_AW-1:0]    feat_waddr;
   logic [FEAT_AW-1:0]    feat_raddr;
   logic [VALUE_BITS-1:0] feat_rdata;

   // slot table
   dti_slot_op_type       slot_op;
   logic [NODE_AW-1:0]    op_addr;
   logic [NODE_AW-1:0]    look_addr;
   logic                  look_valid;
   logic                  root_valid;
   logic [CNT_W-1:0]      node_count;

   // decode
   logic [NODE_AW-1:0]    id_addr;
   logic                  id_in_range;
   logic                  room;
   logic [FCNT_W-1:0]     loaded_next;
   logic [CLASS_W-1:0]    nd_class;
   logic [LINK_W-1:0]     nd_right;
   logic [LINK_W-1:0]     nd_left;
   logic [FEAT_W-1:0]     nd_feat;
   logic [VALUE_BITS-1:0] nd_thr;
   logic                  nd_has_link;
   logic                  nd_internal;
   logic                  go_left;
   logic [LINK_W-1:0]     next_link;
   logic                  next_in_range;

   assign id_addr     = NODE_AW'(req_node_id);
   assign id_in_range = 32'(req_node_id) < NODES;
   assign room        = 32'(loaded_ff) < FEATURES;
   assign loaded_next = room ? loaded_ff + FCNT_W'(1) : loaded_ff;
   assign feat_waddr  = FEAT_AW'(loaded_ff);
   assign node_wdata  = {req_threshold, req_split_feature, req_left_child,
                         req_right_child, req_class_id};

   assign nd_class    = node_rdata[RIGHT_LSB-1:0];
   assign nd_right    = node_rdata[LEFT_LSB-1:RIGHT_LSB];
   assign nd_left     = node_rdata[FEAT_LSB-1:LEFT_LSB];
   assign nd_feat     = node_rdata[THR_LSB-1:FEAT_LSB];
   assign nd_thr      = node_rdata[NODE_W-1:THR_LSB];
   // a link of all ones is "no child"
   assign nd_has_link = (nd_left != '1) || (nd_right != '1);
   assign nd_internal = nd_has_link && !nd_feat[FEAT_W-1];

   assign go_left       = $signed(feat_rdata) <= $signed(thr_ff);
   assign next_link     = go_left ? left_ff : right_ff;
   assign next_in_range = !next_link[LINK_W-1] && (32'(next_link[ID_W-1:0]) < NODES);

   always_comb begin
      state_in       = state_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_class_in   = '0;
      loaded_in      = loaded_ff;
      walk_loaded_in = walk_loaded_ff;
      largest_in     = largest_ff;
      steps_in       = steps_ff;
      rm_addr_in     = rm_addr_ff;
      thr_in         = thr_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      node_we        = 1'b0;
      node_raddr     = '0;
      feat_we        = 1'b0;
      feat_raddr     = '0;
      slot_op        = '0;
      op_addr        = id_addr;
      look_addr      = id_addr;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (dti_kind_type'(req_kind))
                  KIND_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     if (!id_in_range) begin
                        rsp_status_in = STATUS_MISSING;
                     end else if (look_valid) begin
                        rsp_status_in = STATUS_DUPLICATE;
                     end else begin
                        rsp_status_in = STATUS_OK;
                        node_we       = 1'b1;
                        slot_op.set   = 1'b1;
                        if (!req_split_feature[FEAT_W-1] &&
                            (req_split_feature[FEAT_IDX_W-1:0] > largest_ff)) begin
                           largest_in = req_split_feature[FEAT_IDX_W-1:0];
                        end
                     end
                  end
                  KIND_REMOVE: begin
                     if (!id_in_range || !look_valid) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_MISSING;
                     end else begin
                        node_raddr = id_addr;
                        rm_addr_in = id_addr;
                        state_in   = S_REMOVE;
                     end
                  end
                  KIND_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_OK;
                     slot_op.wipe  = 1'b1;
                     largest_in    = '0;
                  end
                  KIND_SAMPLE: begin
                     feat_we   = room;
                     loaded_in = loaded_next;
                     if (req_last) begin
                        // walk works from a snapshot; the vector restarts now
                        loaded_in      = '0;
                        walk_loaded_in = loaded_next;
                        if (32'(loaded_next) <= 32'(largest_ff)) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = STATUS_SHORT;
                        end else if (!root_valid) begin
                           rsp_strobe_in = 1'b1;
                           rsp_status_in = STATUS_WALK_MISSING;
                        end else begin
                           node_raddr = '0;
                           steps_in   = '0;
                           state_in   = S_NODE;
                        end
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_REMOVE: begin
            op_addr       = rm_addr_ff;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            if (nd_has_link) begin
               rsp_status_in = STATUS_HAS_CHILDREN;
            end else begin
               rsp_status_in = STATUS_OK;
               slot_op.drop  = 1'b1;
            end
         end

         S_NODE: begin
            if (!nd_internal) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_class_in  = nd_class;
               state_in      = S_IDLE;
            end else if (32'(nd_feat[FEAT_IDX_W-1:0]) >= 32'(walk_loaded_ff)) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_SHORT;
               state_in      = S_IDLE;
            end else if (32'(steps_ff) >= WALK_LIMIT) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_DEPTH;
               state_in      = S_IDLE;
            end else begin
               feat_raddr = FEAT_AW'(nd_feat[FEAT_IDX_W-1:0]);
               thr_in     = nd_thr;
               left_in    = nd_left;
               right_in   = nd_right;
               state_in   = S_FEATURE;
            end
         end

         S_FEATURE: begin
            look_addr = NODE_AW'(next_link[ID_W-1:0]);
            if (!next_in_range || !look_valid) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_WALK_MISSING;
               state_in      = S_IDLE;
            end else begin
               node_raddr = look_addr;
               steps_in   = steps_ff + STEP_W'(1);
               state_in   = S_NODE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         rsp_status_ff <= STATUS_OK;
         rsp_class_ff  <= '0;
         loaded_ff     <= '0;
         largest_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_status_ff <= rsp_status_in;
         rsp_class_ff  <= rsp_class_in;
         loaded_ff     <= loaded_in;
         largest_ff    <= largest_in;
      end
      walk_loaded_ff <= walk_loaded_in;
      steps_ff       <= steps_in;
      rm_addr_ff     <= rm_addr_in;
      thr_ff         <= thr_in;
      left_ff        <= left_in;
      right_ff       <= right_in;
   end

   dti_slot_table #(
      .NODES(NODES)
   ) u_slot_table (
      .clock      (clock),
      .reset      (reset),
      .op         (slot_op),
      .op_addr    (op_addr),
      .look_addr  (look_addr),
      .look_valid (look_valid),
      .root_valid (root_valid),
      .count      (node_count)
   );

   dti_ram #(
      .WIDTH(NODE_W),
      .DEPTH(NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (id_addr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   dti_ram #(
      .WIDTH(VALUE_BITS),
      .DEPTH(FEATURES)
   ) u_feature_ram (
      .clock   (clock),
      .wr_en   (feat_we),
      .wr_addr (feat_waddr),
      .wr_data (req_feature_value),
      .rd_addr (feat_raddr),
      .rd_data (feat_rdata)
   );

   // node count is already updated when the response beat is shown
   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_class_out  = rsp_class_ff;
   assign rsp_node_total = TOTAL_W'(node_count);

endmodule

/* hw/rtl/dti_ram.sv */
module dti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dti_slot_table.sv */
module dti_slot_table #(
   parameter int NODES = 256
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dti_pkg::dti_slot_op_type                op,
   input  logic [$clog2(NODES)-1:0]                op_addr,
   input  logic [$clog2(NODES)-1:0]                look_addr,
   output logic                                    look_valid,
   output logic                                    root_valid,
   output logic [$clog2(NODES+1)-1:0]              count
);

   import dti_pkg::*;

   localparam int CNT_W = $clog2(NODES + 1);

   logic [NODES-1:0] valid_ff;
   logic [NODES-1:0] valid_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (op.wipe) begin
         valid_in = '0;
         count_in = '0;
      end else if (op.set) begin
         valid_in[op_addr] = 1'b1;
         count_in          = count_ff + CNT_W'(1);
      end else if (op.drop) begin
         valid_in[op_addr] = 1'b0;
         count_in          = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   assign look_valid = valid_ff[look_addr];
   assign root_valid = valid_ff[0];
   assign count      = count_ff;

endmodule
